// File: rtl/core/arpr_pkg.sv
`default_nettype none

package arpr_pkg;

  // Register indexes on the configuration port.
  localparam logic CfgOwnMac = 1'b0;
  localparam logic CfgOwnIp  = 1'b1;

  // Frame checks and limits.
  localparam int unsigned PosW      = 11;
  localparam logic [PosW-1:0] PosMax   = 11'd2047;
  localparam logic [PosW-1:0] PosLastMin = 11'd41;
  localparam logic [PosW-1:0] PosTypeHi  = 11'd12;
  localparam logic [PosW-1:0] PosTypeLo  = 11'd13;
  localparam logic [PosW-1:0] PosOpHi    = 11'd20;
  localparam logic [PosW-1:0] PosOpLo    = 11'd21;
  localparam logic [PosW-1:0] PosIpFirst = 11'd28;
  localparam logic [PosW-1:0] PosIpLast  = 11'd31;

  // Reply byte counter covers replies of up to 64 bytes.
  localparam int unsigned ReplyIdxW = 6;

  // One pending reply: the requester's IP, first wire byte in bits 7:0.
  typedef struct packed {
    logic [31:0] ip;
  } req_t;

  // Reply byte for a given position in the reply frame.
  function automatic logic [7:0] reply_byte(input logic [ReplyIdxW-1:0] idx,
                                            input logic [47:0] mac,
                                            input logic [31:0] ip,
                                            input logic [31:0] rip);
    logic [7:0] b;
    logic [ReplyIdxW-1:0] k;
    b = 8'h00;
    k = '0;
    case (idx) inside
      [6'd0:6'd5]: b = 8'hFF;
      [6'd6:6'd11]: begin
        k = idx - 6'd6;
        b = mac[8*k[2:0] +: 8];
      end
      6'd12: b = 8'h08;
      6'd13: b = 8'h06;
      6'd14: b = 8'h00;
      6'd15: b = 8'h01;
      6'd16: b = 8'h08;
      6'd17: b = 8'h00;
      6'd18: b = 8'h06;
      6'd19: b = 8'h04;
      6'd20: b = 8'h00;
      6'd21: b = 8'h02;
      [6'd22:6'd27]: begin
        k = idx - 6'd22;
        b = mac[8*k[2:0] +: 8];
      end
      [6'd28:6'd31]: begin
        k = idx - 6'd28;
        b = ip[8*k[1:0] +: 8];
      end
      [6'd38:6'd41]: begin
        k = idx - 6'd38;
        b = rip[8*k[1:0] +: 8];
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/arpr_front.sv
`default_nettype none

module arpr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          rx_last_i,
  output logic               req_vld_o,
  output arpr_pkg::req_t     req_o
);
  import arpr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      match_q, match_d;
  logic [31:0]     rip_q, rip_d;
  logic [1:0]      sh;

  // Check the ethertype and opcode bytes and capture the sender IP.
  always_comb begin
    match_d = match_q;
    rip_d   = rip_q;
    sh      = 2'(pos_q - PosIpFirst);
    case (pos_q)
      PosTypeHi: if (rx_byte_i != 8'h08) match_d[0] = 1'b0;
      PosTypeLo: if (rx_byte_i != 8'h06) match_d[1] = 1'b0;
      PosOpHi:   if (rx_byte_i != 8'h00) match_d[2] = 1'b0;
      PosOpLo:   if (rx_byte_i != 8'h01) match_d[3] = 1'b0;
      default: ;
    endcase
    if (pos_q >= PosIpFirst && pos_q <= PosIpLast) begin
      rip_d[8*sh +: 8] = rx_byte_i;
    end
  end

  // A matching frame of full length queues one reply on its final word.
  assign req_vld_o = accept_i && rx_last_i && (match_d == 4'hF) && (pos_q >= PosLastMin);
  assign req_o.ip  = rip_d;

  // Frame position counter and match flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 4'hF;
      rip_q   <= '0;
    end else if (accept_i) begin
      rip_q <= rip_d;
      if (rx_last_i) begin
        pos_q   <= '0;
        match_q <= 4'hF;
      end else begin
        match_q <= match_d;
        if (pos_q < PosMax) pos_q <= pos_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/arpr_queue.sv
`default_nettype none

module arpr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  arpr_pkg::req_t     push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output arpr_pkg::req_t     pop_data_o,
  output logic               empty_o
);
  import arpr_pkg::*;

  req_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage for pending replies.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/arpr_back.sv
`default_nettype none

module arpr_back #(
  parameter int unsigned REPLY_BYTES = 60
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [47:0]   own_mac_i,
  input  wire logic [31:0]   own_ip_i,
  input  wire logic          q_empty_i,
  input  arpr_pkg::req_t     q_data_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [7:0]         tx_byte_o,
  output logic               tx_last_o
);
  import arpr_pkg::*;

  localparam logic [ReplyIdxW-1:0] LastIdx = ReplyIdxW'(REPLY_BYTES - 1);

  logic [ReplyIdxW-1:0] idx_q;
  logic                 out_vld_q;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;
  logic                 advance;
  logic                 at_last;

  // Produce a word whenever a reply is pending and the output register frees up.
  assign advance = !q_empty_i && (!out_vld_q || pop_i);
  assign at_last = (idx_q == LastIdx);
  assign q_pop_o = advance && at_last;

  assign empty_o   = !out_vld_q;
  assign tx_byte_o = out_byte_q;
  assign tx_last_o = out_last_q;

  // Reply word counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        out_vld_q <= 1'b1;
        idx_q     <= at_last ? '0 : idx_q + 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= reply_byte(idx_q, own_mac_i, own_ip_i, q_data_i.ip);
      out_last_q <= at_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/arp_request_responder_unit.sv
`default_nettype none

// ARP responder. Received frame bytes enter one word per cycle through push/full;
// each frame whose ethertype is 08 06, whose opcode is 00 01 and which holds at
// least 42 bytes yields one REPLY_BYTES-long ARP reply (broadcast destination,
// own MAC and IP as sender, the requester's IP as target, zero padded), read out
// one word per cycle through empty/pop. The parser takes a word every cycle while
// full is low; a reply streams out at one word per cycle while pop is held, so for
// back-to-back requests shorter than REPLY_BYTES the replies set the sustained rate.
// Up to two replies wait in a queue between parser and generator; full rises
// while that queue holds two. The final byte of a request queues its reply as it
// is accepted; the first reply word reaches the outputs through an output register.
// The target IP is not checked. own_mac (index 0) and own_ip (index 1) are stored
// first wire byte in bits 7:0; users must write them only while idle (unenforced).
module arp_request_responder_unit #(
  parameter int unsigned REPLY_BYTES = 60
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [47:0]   cfg_data_i,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          rx_last_i,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         tx_byte_o,
  output logic               tx_last_o
);
  import arpr_pkg::*;

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic        accept;
  logic        req_vld;
  req_t        req;
  logic        q_full, q_empty, q_pop;
  req_t        q_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOwnMac: own_mac_q <= cfg_data_i;
        CfgOwnIp:  own_ip_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  arpr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .rx_last_i (rx_last_i),
    .req_vld_o (req_vld),
    .req_o     (req)
  );

  arpr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_vld),
    .push_data_i (req),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_data),
    .empty_o     (q_empty)
  );

  arpr_back #(
    .REPLY_BYTES (REPLY_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .own_mac_i (own_mac_q),
    .own_ip_i  (own_ip_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .tx_byte_o (tx_byte_o),
    .tx_last_o (tx_last_o)
  );

  // A reply request is never queued while the queue is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld |-> !q_full) else $error("reply queue overflow");

  // A reply leaves the queue only when its final word is loaded for output.
  a_last_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (!empty && tx_last_o)) else $error("final reply word missing");

  // Nothing is released from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("reply queue underflow");

endmodule

`default_nettype wire

// File: dv/tb_arp_request_responder_unit.sv
`default_nettype none

module tb_arp_request_responder_unit;
  import arpr_pkg::*;

  localparam int unsigned REPLY_N = 60;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_TAIL = 10;
  localparam int unsigned HOLD_CYCLES = 300;

  // Frame offsets that the responder looks at.
  localparam int OFS_TYPE_HI = 12;
  localparam int OFS_TYPE_LO = 13;
  localparam int OFS_OP_HI = 20;
  localparam int OFS_OP_LO = 21;
  localparam int OFS_SIP = 28;
  localparam int MIN_REQ_LEN = 42;
  localparam logic [10:0] POS_SAT = 11'd2047;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } reply_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [47:0] cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte;
  logic        rx_last;
  logic        empty;
  logic        pop;
  logic [7:0]  tx_byte;
  logic        tx_last;

  // Predictor copy of the station registers and parser state.
  logic [47:0] stn_mac;
  logic [31:0] stn_ip;
  logic [10:0] frame_pos;
  logic [3:0]  hdr_ok;
  logic [31:0] req_ip;

  reply_word_t reply_q[$];
  int          mismatch_cnt;
  int          src_idle_pct;
  int          sink_idle_pct;
  logic        hold_req;
  int          hold_left;
  int          stall_cnt;

  arp_request_responder_unit #(
    .REPLY_BYTES(REPLY_N)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte),
    .rx_last_i  (rx_last),
    .empty      (empty),
    .pop        (pop),
    .tx_byte_o  (tx_byte),
    .tx_last_o  (tx_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Queue the reply frame that answers the request just parsed.
  function automatic void queue_arp_reply();
    logic [7:0] f [64];
    reply_word_t w;
    for (int k = 0; k < 64; k++) f[k] = 8'h00;
    for (int k = 0; k < 6; k++) begin
      f[k] = 8'hFF;
      f[6 + k] = stn_mac[8*k +: 8];
      f[22 + k] = stn_mac[8*k +: 8];
    end
    f[12] = 8'h08; f[13] = 8'h06;
    f[14] = 8'h00; f[15] = 8'h01;
    f[16] = 8'h08; f[17] = 8'h00;
    f[18] = 8'h06; f[19] = 8'h04;
    f[20] = 8'h00; f[21] = 8'h02;
    for (int k = 0; k < 4; k++) begin
      f[28 + k] = stn_ip[8*k +: 8];
      f[38 + k] = req_ip[8*k +: 8];
    end
    for (int k = 0; k < REPLY_N; k++) begin
      w.data = f[k];
      w.is_last = (k == REPLY_N - 1);
      reply_q.push_back(w);
    end
  endfunction

  // Advance the parser by one received byte, queueing a reply where one is due.
  function automatic void parse_rx_byte(input logic [7:0] b, input logic is_last);
    logic [10:0] at;
    logic hit;
    at = frame_pos;
    case (at)
      11'd12: if (b != 8'h08) hdr_ok[0] = 1'b0;
      11'd13: if (b != 8'h06) hdr_ok[1] = 1'b0;
      11'd20: if (b != 8'h00) hdr_ok[2] = 1'b0;
      11'd21: if (b != 8'h01) hdr_ok[3] = 1'b0;
      default: ;
    endcase
    if (at >= 11'd28 && at <= 11'd31) req_ip[8*(at - 11'd28) +: 8] = b;
    if (!is_last) begin
      if (frame_pos != POS_SAT) frame_pos = frame_pos + 11'd1;
      return;
    end
    hit = (hdr_ok == 4'hF) && (at >= 11'd41);
    frame_pos = '0;
    hdr_ok = 4'hF;
    if (hit) queue_arp_reply();
  endfunction

  // Offer one frame word, with random idle cycles ahead of it, and wait until taken.
  task automatic send_rx_word(input logic [7:0] b, input logic is_last);
    if ($urandom_range(99) < src_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    push <= 1'b1;
    rx_byte <= b;
    rx_last <= is_last;
    do @(posedge clk_i); while (full);
    parse_rx_byte(b, is_last);
  endtask

  // Send an ARP request frame; fill < 0 gives random filler, bad_at >= 0 spoils that byte.
  task automatic send_request(input int len, input logic [31:0] sip, input int bad_at,
                              input int fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      case (i)
        OFS_TYPE_HI: b = 8'h08;
        OFS_TYPE_LO: b = 8'h06;
        OFS_OP_HI: b = 8'h00;
        OFS_OP_LO: b = 8'h01;
        OFS_SIP: b = sip[7:0];
        OFS_SIP + 1: b = sip[15:8];
        OFS_SIP + 2: b = sip[23:16];
        OFS_SIP + 3: b = sip[31:24];
        default: ;
      endcase
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      send_rx_word(b, i == len - 1);
    end
  endtask

  // Stop offering words and wait until every expected reply word has been taken.
  task automatic drain_replies();
    push <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [47:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgOwnMac) stn_mac = data;
    else stn_ip = data[31:0];
  endtask

  task automatic write_random_station();
    write_reg(CfgOwnMac, 48'({$urandom, $urandom}));
    write_reg(CfgOwnIp, {16'h0000, $urandom});
  endtask

  // All-ones station registers and an all-ones request of minimum length apart from its header fields.
  task automatic test_directed();
    write_reg(CfgOwnMac, 48'hFFFF_FFFF_FFFF);
    write_reg(CfgOwnIp, 48'h0000_FFFF_FFFF);
    send_request(MIN_REQ_LEN, 32'hFFFF_FFFF, -1, 8'hFF);
    drain_replies();
  endtask

  // A full-length request with one spoiled header byte gets no reply.
  task automatic test_mismatch();
    int bad;
    write_random_station();
    case ($urandom_range(3))
      0: bad = OFS_TYPE_HI;
      1: bad = OFS_TYPE_LO;
      2: bad = OFS_OP_HI;
      default: bad = OFS_OP_LO;
    endcase
    send_request(MIN_REQ_LEN, $urandom, bad, -1);
    drain_replies();
  endtask

  // The receiver holds off while requests keep coming, so the reply queue fills up;
  // a short frame follows, and the sender then waits for every reply.
  task automatic test_backpressure();
    write_random_station();
    hold_req = 1'b1;
    send_request(MIN_REQ_LEN, $urandom, -1, -1);
    send_request(MIN_REQ_LEN, $urandom, -1, -1);
    send_request($urandom_range(1, MIN_REQ_LEN - 1), $urandom, -1, -1);
    drain_replies();
  endtask

  // Take reply words and compare them with the oldest expected word.
  always @(posedge clk_i) begin
    reply_word_t w;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected reply word, expected none, actual %02h last %0b",
                   $time, tx_byte, tx_last);
        end else begin
          w = reply_q.pop_front();
          if (tx_byte !== w.data) begin
            mismatch_cnt++;
            $display("%0t: tx_byte mismatch, expected %02h, actual %02h",
                     $time, w.data, tx_byte);
          end
          if (tx_last !== w.is_last) begin
            mismatch_cnt++;
            $display("%0t: tx_last mismatch, expected %0b, actual %0b",
                     $time, w.is_last, tx_last);
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("tb_arp_request_responder_unit: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgOwnMac;
    cfg_data = '0;
    push = 1'b0;
    rx_byte = '0;
    rx_last = 1'b0;
    pop = 1'b0;
    stn_mac = '0;
    stn_ip = '0;
    frame_pos = '0;
    hdr_ok = 4'hF;
    req_ip = '0;
    mismatch_cnt = 0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_cnt = 0;
    src_idle_pct = 6;
    sink_idle_pct = 80;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender rarely idles, receiver mostly idles.
    test_directed();

    // The other way round.
    src_idle_pct = 80;
    sink_idle_pct = 6;
    test_mismatch();

    // Neither side idles.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();

    drain_replies();
    if (mismatch_cnt == 0) begin
      $display("tb_arp_request_responder_unit: PASS");
    end else begin
      $display("tb_arp_request_responder_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
